// ===== rtl/bslr_pkg.sv =====
// ----------------------------------------------------------------------------
// bslr_pkg
// Shared types and constants for the short/long/repeat key classifier.
// ----------------------------------------------------------------------------
package bslr_pkg;

  // Configuration register widths
  localparam int unsigned SHORT_W  = 10;
  localparam int unsigned LONG_W   = 16;
  localparam int unsigned REP_W    = 10;
  localparam int unsigned ACCEL_W  = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned NOW_W      = 32;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_MIN  = 3'd0,
    REG_LONG_PRESS = 3'd1,
    REG_REP_SLOW   = 3'd2,
    REG_REP_FAST   = 3'd3,
    REG_ACCEL      = 3'd4,
    REG_REP_EN     = 3'd5
  } cfg_reg_t;

  // Reset values
  localparam logic [SHORT_W-1:0] SHORT_MIN_RST  = 10'd25;
  localparam logic [LONG_W-1:0]  LONG_PRESS_RST = 16'd800;
  localparam logic [REP_W-1:0]   REP_SLOW_RST   = 10'd150;
  localparam logic [REP_W-1:0]   REP_FAST_RST   = 10'd50;
  localparam logic [ACCEL_W-1:0] ACCEL_RST      = 16'd2000;

  // Action codes
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_SYNC   = 1'b1;

  // Key line levels (active low)
  localparam logic KEY_PRESSED  = 1'b0;
  localparam logic KEY_RELEASED = 1'b1;

  // Configuration settings as seen by the datapath
  typedef struct packed {
    logic [SHORT_W-1:0] short_min;
    logic [LONG_W-1:0]  long_press;
    logic [REP_W-1:0]   rep_slow;
    logic [REP_W-1:0]   rep_fast;
    logic [ACCEL_W-1:0] accel_after;
    logic               rep_en;
  } cfg_t;

  // One result
  typedef struct packed {
    logic short_press;
    logic long_press;
    logic repeat_tick;
    logic press_edge;
    logic is_held;
  } result_t;

endpackage

// ===== rtl/button_short_long_repeat.sv =====
// ----------------------------------------------------------------------------
// button_short_long_repeat
// Classifies one active-low key into short press, long press and auto-repeat
// events from timestamped samples. Each accepted request gives one result.
// The block takes one request per clock while the result register is free or
// draining, with no stall of its own. A request passes the input register,
// then one pass that updates the key state and loads the result register,
// which raises out_valid. Time differences wrap modulo 2^TIME_BITS; only the
// low TIME_BITS bits of in_now_ms are used. Configuration writes are taken at
// any time and should be made while no sample is in flight.
// ----------------------------------------------------------------------------
module button_short_long_repeat #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Sample requests
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_action,
  input  logic                                in_key_level,
  input  logic [bslr_pkg::NOW_W-1:0]          in_now_ms,
  // Results
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_short_press,
  output logic                                out_long_press,
  output logic                                out_repeat_tick,
  output logic                                out_press_edge,
  output logic                                out_is_held,
  // Configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bslr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bslr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  typedef logic [TIME_BITS-1:0] tm_t;

  // Configuration registers
  bslr_pkg::cfg_t cfg_r;

  // Input stage
  logic s1_valid_r;
  logic s1_action_r;
  logic s1_level_r;
  tm_t  s1_now_r;

  // Key state
  logic last_level_r, last_level_nxt;
  tm_t  press_time_r, press_time_nxt;
  logic long_done_r,  long_done_nxt;
  tm_t  last_rep_r,   last_rep_nxt;

  // Result stage
  logic               out_valid_r;
  bslr_pkg::result_t  res_r, res_nxt;

  logic advance;

  // Datapath temporaries
  logic is_edge, is_press, is_release;
  tm_t  pt_eff, lrt_eff;
  logic ld_eff;
  tm_t  hold_old, hold, since_rep;
  logic [bslr_pkg::REP_W-1:0] interval;
  logic held;
  logic sp, lp, rt;

  // Handshake: stage 1 moves when the result register is free or draining
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  // Configuration write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_min   <= bslr_pkg::SHORT_MIN_RST;
      cfg_r.long_press  <= bslr_pkg::LONG_PRESS_RST;
      cfg_r.rep_slow    <= bslr_pkg::REP_SLOW_RST;
      cfg_r.rep_fast    <= bslr_pkg::REP_FAST_RST;
      cfg_r.accel_after <= bslr_pkg::ACCEL_RST;
      cfg_r.rep_en      <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bslr_pkg::REG_SHORT_MIN:  cfg_r.short_min   <= cfg_data[bslr_pkg::SHORT_W-1:0];
        bslr_pkg::REG_LONG_PRESS: cfg_r.long_press  <= cfg_data[bslr_pkg::LONG_W-1:0];
        bslr_pkg::REG_REP_SLOW:   cfg_r.rep_slow    <= cfg_data[bslr_pkg::REP_W-1:0];
        bslr_pkg::REG_REP_FAST:   cfg_r.rep_fast    <= cfg_data[bslr_pkg::REP_W-1:0];
        bslr_pkg::REG_ACCEL:      cfg_r.accel_after <= cfg_data[bslr_pkg::ACCEL_W-1:0];
        bslr_pkg::REG_REP_EN:     cfg_r.rep_en      <= cfg_data[0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action_r <= in_action;
      s1_level_r  <= in_key_level;
      s1_now_r    <= in_now_ms[TIME_BITS-1:0];
    end
  end

  // Classification pass
  always_comb begin
    is_edge    = (s1_level_r != last_level_r);
    is_press   = is_edge && (s1_level_r == bslr_pkg::KEY_PRESSED);
    is_release = is_edge && (s1_level_r == bslr_pkg::KEY_RELEASED);
    held       = (s1_level_r == bslr_pkg::KEY_PRESSED);

    // a press edge restarts the hold
    pt_eff  = is_press ? s1_now_r : press_time_r;
    lrt_eff = is_press ? s1_now_r : last_rep_r;
    ld_eff  = is_press ? 1'b0     : long_done_r;

    hold_old  = s1_now_r - press_time_r;
    hold      = s1_now_r - pt_eff;
    since_rep = s1_now_r - lrt_eff;

    sp = is_release && !long_done_r &&
         (hold_old > tm_t'(cfg_r.short_min));
    lp = held && !ld_eff && (hold >= tm_t'(cfg_r.long_press));

    interval = (hold > tm_t'(cfg_r.accel_after)) ? cfg_r.rep_fast : cfg_r.rep_slow;
    rt = cfg_r.rep_en && held && (since_rep >= tm_t'(interval));

    if (s1_action_r == bslr_pkg::ACT_SYNC) begin
      last_level_nxt = s1_level_r;
      press_time_nxt = s1_now_r;
      last_rep_nxt   = s1_now_r;
      long_done_nxt  = held;
      res_nxt.short_press = 1'b0;
      res_nxt.long_press  = 1'b0;
      res_nxt.repeat_tick = 1'b0;
      res_nxt.press_edge  = 1'b0;
    end else begin
      last_level_nxt = s1_level_r;
      press_time_nxt = pt_eff;
      last_rep_nxt   = rt ? s1_now_r : lrt_eff;
      long_done_nxt  = ld_eff | lp;
      res_nxt.short_press = sp;
      res_nxt.long_press  = lp;
      res_nxt.repeat_tick = rt;
      res_nxt.press_edge  = is_press;
    end
    res_nxt.is_held = held;
  end

  // Key state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r <= bslr_pkg::KEY_RELEASED;
      press_time_r <= '0;
      long_done_r  <= 1'b0;
      last_rep_r   <= '0;
    end else if (advance) begin
      last_level_r <= last_level_nxt;
      press_time_r <= press_time_nxt;
      long_done_r  <= long_done_nxt;
      last_rep_r   <= last_rep_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_short_press = res_r.short_press;
  assign out_long_press  = res_r.long_press;
  assign out_repeat_tick = res_r.repeat_tick;
  assign out_press_edge  = res_r.press_edge;
  assign out_is_held     = res_r.is_held;

endmodule

// ===== rtl/bslr_checker.sv =====
// ----------------------------------------------------------------------------
// bslr_checker
// Port-level checks for the key classifier, bound to the top level.
// ----------------------------------------------------------------------------
module bslr_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_short_press,
  input logic out_long_press,
  input logic out_repeat_tick,
  input logic out_press_edge,
  input logic out_is_held
);

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_short_press, out_long_press, out_repeat_tick,
               out_press_edge, out_is_held}))
    else $error("stalled result changed");

  // short press only on release, alone
  a_short_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_short_press |->
      !out_is_held && !out_long_press && !out_repeat_tick && !out_press_edge)
    else $error("short press with key held or other event");

  // press, long and repeat events only while held
  a_held_events: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_press_edge || out_long_press || out_repeat_tick) |->
      out_is_held)
    else $error("held event reported with key released");

endmodule

bind button_short_long_repeat bslr_checker u_bslr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_short_press (out_short_press),
  .out_long_press  (out_long_press),
  .out_repeat_tick (out_repeat_tick),
  .out_press_edge  (out_press_edge),
  .out_is_held     (out_is_held)
);
